// File: sv/asp_pkg.sv
`default_nettype none
package asp_pkg;

    // Field widths of one glyph and one record
    localparam int CODE_W    = 8;
    localparam int DIM_W     = 12;
    localparam int LIMIT_W   = 13;
    localparam int EXTENT_W  = 13;
    localparam int POS_W     = 12;
    localparam int PAGE_W    = 16;
    localparam int REC_SLOTS = 3;

    // Cursor width default and packed bus widths
    localparam int COORD_BITS_DEF = 13;
    localparam int S_DATA_W       = 32;
    localparam int M_DATA_W       = 80;

    // Limit register reset and clamp values
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd2048;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX   = 13'd4096;
    localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 13'd1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_HEIGHT = 1'd1;

    // Record kinds
    localparam logic KIND_GLYPH = 1'b0;
    localparam logic KIND_PAGE  = 1'b1;

    // One result record
    typedef struct packed {
        logic                kind;
        logic [CODE_W-1:0]   code;
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic [EXTENT_W-1:0] w;
        logic [EXTENT_W-1:0] h;
        logic [PAGE_W-1:0]   page;
    } rec_t;

    // All records caused by one glyph: page close, placement, final flush
    typedef struct packed {
        logic [REC_SLOTS-1:0]       pres;
        rec_t [REC_SLOTS-1:0]       rec;
    } bundle_t;

endpackage
`default_nettype wire

// File: sv/asp_place.sv
`default_nettype none
module asp_place
    import asp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               fire,
    input  wire logic [CODE_W-1:0]  code,
    input  wire logic [DIM_W-1:0]   glyph_w,
    input  wire logic [DIM_W-1:0]   glyph_h,
    input  wire logic               fin,
    input  wire logic [LIMIT_W-1:0] width_limit,
    input  wire logic [LIMIT_W-1:0] height_limit,
    output bundle_t                 bundle
);

    // Sum width: room for a cursor plus a glyph dimension, and for the limits
    localparam int SW = ((COORD_BITS > LIMIT_W) ? COORD_BITS : LIMIT_W) + 1;

    logic [COORD_BITS-1:0] cx_reg, cx_next;
    logic [COORD_BITS-1:0] cy_reg, cy_next;
    logic [DIM_W-1:0]      rt_reg, rt_next;
    logic [EXTENT_W-1:0]   uw_reg, uw_next;
    logic [EXTENT_W-1:0]   uh_reg, uh_next;
    logic [PAGE_W-1:0]     pg_reg, pg_next;

    logic                  wrap, close, flush;
    logic [COORD_BITS-1:0] cx1, cy1, cx2, cy2, cx3;
    logic [DIM_W-1:0]      rt1, rt2, rt3;
    logic [EXTENT_W-1:0]   uw2, uh2, uw3, uh3;
    logic [PAGE_W-1:0]     pg2;
    logic [SW-1:0]         xsum, ywrap, yclose, xend, ysum, cx2_w, cy2_w, cx3_w;

    // Place one glyph against the registered cursors
    always_comb begin
        // Row wrap, judged with the previous row's tallest glyph
        xsum  = SW'(cx_reg) + SW'(glyph_w);
        wrap  = xsum >= SW'(width_limit);
        ywrap = SW'(cy_reg) + SW'(rt_reg);
        cx1   = wrap ? '0 : cx_reg;
        cy1   = wrap ? ywrap[COORD_BITS-1:0] : cy_reg;
        rt1   = wrap ? '0 : rt_reg;

        // Page close
        yclose = SW'(cy1) + SW'(glyph_h);
        close  = yclose >= SW'(height_limit);
        cx2    = close ? '0 : cx1;
        cy2    = close ? '0 : cy1;
        rt2    = close ? '0 : rt1;
        uw2    = close ? '0 : uw_reg;
        uh2    = close ? '0 : uh_reg;
        pg2    = close ? pg_reg + PAGE_W'(1) : pg_reg;

        // Row height after placement
        rt3 = (glyph_h > rt2) ? glyph_h : rt2;

        // Advance cursor and grow the used extent
        xend  = SW'(cx2) + SW'(glyph_w);
        cx3   = xend[COORD_BITS-1:0];
        cx3_w = SW'(cx3);
        uw3   = (cx3_w > SW'(uw2)) ? cx3_w[EXTENT_W-1:0] : uw2;
        ysum  = SW'(cy2) + SW'(rt3);
        uh3   = (ysum > SW'(uh2)) ? ysum[EXTENT_W-1:0] : uh2;
        flush = fin && (uw3 != '0) && (uh3 != '0);

        cx2_w = SW'(cx2);
        cy2_w = SW'(cy2);

        // Page close record
        bundle.pres[0]     = close;
        bundle.rec[0].kind = KIND_PAGE;
        bundle.rec[0].code = '0;
        bundle.rec[0].x    = '0;
        bundle.rec[0].y    = '0;
        bundle.rec[0].w    = uw_reg;
        bundle.rec[0].h    = uh_reg;
        bundle.rec[0].page = pg_reg;

        // Placement record
        bundle.pres[1]     = 1'b1;
        bundle.rec[1].kind = KIND_GLYPH;
        bundle.rec[1].code = code;
        bundle.rec[1].x    = cx2_w[POS_W-1:0];
        bundle.rec[1].y    = cy2_w[POS_W-1:0];
        bundle.rec[1].w    = EXTENT_W'(glyph_w);
        bundle.rec[1].h    = EXTENT_W'(glyph_h);
        bundle.rec[1].page = pg2;

        // Final page extent
        bundle.pres[2]     = flush;
        bundle.rec[2].kind = KIND_PAGE;
        bundle.rec[2].code = '0;
        bundle.rec[2].x    = '0;
        bundle.rec[2].y    = '0;
        bundle.rec[2].w    = uw3;
        bundle.rec[2].h    = uh3;
        bundle.rec[2].page = pg2;

        // Next state; the final glyph starts a new run
        if (fin) begin
            cx_next = '0;
            cy_next = '0;
            rt_next = '0;
            uw_next = '0;
            uh_next = '0;
            pg_next = '0;
        end else begin
            cx_next = cx3;
            cy_next = cy2;
            rt_next = rt3;
            uw_next = uw3;
            uh_next = uh3;
            pg_next = pg2;
        end
    end

    // Hold packing state; advance on each placed glyph
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg <= '0;
            cy_reg <= '0;
            rt_reg <= '0;
            uw_reg <= '0;
            uh_reg <= '0;
            pg_reg <= '0;
        end else if (fire) begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            rt_reg <= rt_next;
            uw_reg <= uw_next;
            uh_reg <= uh_next;
            pg_reg <= pg_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/asp_emit.sv
`default_nettype none
module asp_emit
    import asp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  bundle_t                  bundle,
    output logic                     free,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tuser,
    output logic                     m_tlast
);

    logic [REC_SLOTS-1:0] pres_reg, pres_next;
    rec_t [REC_SLOTS-1:0] rec_reg;
    logic [REC_SLOTS-1:0] sel_mask;
    logic [REC_SLOTS-1:0] rest;
    rec_t                 cur;
    logic                 xfer;

    // Pick the earliest pending record
    always_comb begin
        if (pres_reg[0]) begin
            sel_mask = 3'b001;
            cur      = rec_reg[0];
        end else if (pres_reg[1]) begin
            sel_mask = 3'b010;
            cur      = rec_reg[1];
        end else begin
            sel_mask = 3'b100;
            cur      = rec_reg[2];
        end
        rest = pres_reg & ~sel_mask;
    end

    assign m_tvalid = |pres_reg;
    assign xfer     = m_tvalid && m_tready;
    assign free     = (pres_reg == '0) || (xfer && (rest == '0));
    assign m_tlast  = (rest == '0);
    assign m_tuser  = cur.kind;
    assign m_tdata  = {6'd0, cur.page, cur.h, cur.w, cur.y, cur.x, cur.code};

    // Drop each record once transferred; load a new bundle when drained
    always_comb begin
        if (load) begin
            pres_next = bundle.pres;
        end else if (xfer) begin
            pres_next = rest;
        end else begin
            pres_next = pres_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pres_reg <= '0;
        end else begin
            pres_reg <= pres_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg <= bundle.rec;
        end
    end

endmodule
`default_nettype wire

// File: sv/atlas_shelf_packer.sv
// Channel   Dir  tdata (low bit up)                          tuser        tlast
// s_        in   glyph_code, glyph_width, glyph_height       -            final_glyph
// m_        out  tag_code, pos_x, pos_y, extent_w, extent_h, record_kind  last_of_glyph
//                page_number, zero pad to 80 bits
// cfg_      in   write enable, register index, 13-bit write data
//
// A glyph is placed once it sits in the input register and the result buffer is free;
// its one to three records then leave one per cycle from the result buffer while
// m_tready is high. Glyphs that cause a single record flow at one per cycle when m_
// does not stall; a page close or a final flush adds a record each on the output port.
// Reset (aresetn low, synchronous) clears cursors, page count and both buffers
// and sets both limits to 2048. A stall on m_ backs up into s_tready.
`default_nettype none
module atlas_shelf_packer
    import asp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,   // glyph_code, glyph_width, glyph_height
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata,   // tag_code, pos_x, pos_y, extent_w,
                                                 // extent_h, page_number, zero pad
    output logic                      m_tuser,   // record_kind
    output logic                      m_tlast,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LIMIT_W-1:0]   cfg_wdata
);

    logic [LIMIT_W-1:0]  wlim_reg, hlim_reg;
    logic [LIMIT_W-1:0]  cfg_clamped;
    logic                in_valid_reg, in_valid_next;
    logic [CODE_W-1:0]   code_reg;
    logic [DIM_W-1:0]    w_reg, h_reg;
    logic                fin_reg;
    logic                emit_free;
    logic                fire;
    logic                s_xfer;
    bundle_t             bundle;

    // Clamp written limits into 1..4096
    always_comb begin
        if (cfg_wdata == '0) begin
            cfg_clamped = LIMIT_MIN;
        end else if (cfg_wdata > LIMIT_MAX) begin
            cfg_clamped = LIMIT_MAX;
        end else begin
            cfg_clamped = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlim_reg <= LIMIT_RESET;
            hlim_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PAGE_WIDTH:  wlim_reg <= cfg_clamped;
                REG_PAGE_HEIGHT: hlim_reg <= cfg_clamped;
                default: ;
            endcase
        end
    end

    // Input register: refill in the cycle its glyph is placed
    assign fire     = in_valid_reg && emit_free;
    assign s_tready = !in_valid_reg || fire;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            code_reg <= s_tdata[CODE_W-1:0];
            w_reg    <= s_tdata[CODE_W+DIM_W-1:CODE_W];
            h_reg    <= s_tdata[CODE_W+2*DIM_W-1:CODE_W+DIM_W];
            fin_reg  <= s_tlast;
        end
    end

    asp_place #(
        .COORD_BITS (COORD_BITS)
    ) u_place (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .code         (code_reg),
        .glyph_w      (w_reg),
        .glyph_h      (h_reg),
        .fin          (fin_reg),
        .width_limit  (wlim_reg),
        .height_limit (hlim_reg),
        .bundle       (bundle)
    );

    asp_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .bundle   (bundle),
        .free     (emit_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
